// ----- rtl/sprite_tile_expander_defines.svh -----
// assertion macros used by the sprite tile expander controller
`ifndef SPRITE_TILE_EXPANDER_DEFINES_SVH
`define SPRITE_TILE_EXPANDER_DEFINES_SVH

// checked property, masked while reset is held
`define STE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked property, also evaluated across reset
`define STE_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/ste_pkg.sv -----
// types and constants of the sprite tile expander
package ste_pkg;

  // field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned TILE_W   = 13;
  localparam int unsigned COORD_W  = 11;
  localparam int unsigned SCREEN_W = 10;
  localparam int unsigned IDX_W    = 2;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 48;
  localparam int unsigned OUT_USER_W = 2;

  // configuration register indexes
  localparam logic [IDX_W-1:0] CFG_TILE_BANK     = 2'd0;
  localparam logic [IDX_W-1:0] CFG_FLIP_SCREEN   = 2'd1;
  localparam logic [IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd2;
  localparam logic [IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd3;

  // configuration reset values
  localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RST  = 10'd512;
  localparam logic [SCREEN_W-1:0] SCREEN_HEIGHT_RST = 10'd256;

  // attribute size decode
  localparam logic [BYTE_W-1:0] SIZE_MASK  = 8'h88;
  localparam logic [BYTE_W-1:0] SIZE_LARGE = 8'h88;
  localparam logic [BYTE_W-1:0] SIZE_MID   = 8'h08;

  // size codes: log2 of tiles per side
  localparam logic [1:0] SZ_1X1 = 2'd0;
  localparam logic [1:0] SZ_2X2 = 2'd1;
  localparam logic [1:0] SZ_4X4 = 2'd2;

  // bank weights of code bit 7
  localparam logic [TILE_W-1:0] BANK_WEIGHT_LO = 13'h0800;
  localparam logic [TILE_W-1:0] BANK_WEIGHT_HI = 13'h1000;

  // offset of the vertical wrap copy
  localparam logic [COORD_W-1:0] WRAP_OFFSET = 11'd256;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic step;
  } ste_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic last;
  } ste_sts_t;

endpackage

// ----- rtl/ste_datapath.sv -----
// datapath: config registers, sprite setup, tile walk and output word register
module ste_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [ste_pkg::IDX_W-1:0]           cfg_index,
  input  logic [ste_pkg::SCREEN_W-1:0]        cfg_wdata,
  input  logic [ste_pkg::IN_DATA_W-1:0]       in_tdata,
  input  ste_pkg::ste_cmd_t                   cmd,
  output ste_pkg::ste_sts_t                   sts,
  output logic [ste_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic [ste_pkg::OUT_USER_W-1:0]      out_tuser,
  output logic                                out_tlast
);

  localparam int unsigned CW = ste_pkg::COORD_W;

  // configuration registers
  logic                          tile_bank_r;
  logic                          flip_screen_r;
  logic [ste_pkg::SCREEN_W-1:0]  screen_width_r;
  logic [ste_pkg::SCREEN_W-1:0]  screen_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_bank_r     <= 1'b0;
      flip_screen_r   <= 1'b0;
      screen_width_r  <= ste_pkg::SCREEN_WIDTH_RST;
      screen_height_r <= ste_pkg::SCREEN_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ste_pkg::CFG_TILE_BANK:     tile_bank_r     <= cfg_wdata[0];
        ste_pkg::CFG_FLIP_SCREEN:   flip_screen_r   <= cfg_wdata[0];
        ste_pkg::CFG_SCREEN_WIDTH:  screen_width_r  <= cfg_wdata;
        ste_pkg::CFG_SCREEN_HEIGHT: screen_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // unpack the incoming word
  logic [ste_pkg::BYTE_W-1:0] sprite_y;
  logic [ste_pkg::BYTE_W-1:0] sprite_x_high;
  logic [ste_pkg::BYTE_W-1:0] attr_byte;
  logic [ste_pkg::BYTE_W-1:0] code_byte;

  assign sprite_y      = in_tdata[7:0];
  assign sprite_x_high = in_tdata[15:8];
  assign attr_byte     = in_tdata[23:16];
  assign code_byte     = in_tdata[31:24];

  // sprite setup: size, base tile, start position, flips
  logic [1:0]                  size_ld;
  logic [3:0]                  low_ld;
  logic [ste_pkg::TILE_W-1:0]  base_ld;
  logic [ste_pkg::TILE_W-1:0]  bank_add;
  logic [CW-1:0]               span_ld;
  logic [CW-1:0]               x_raw;
  logic [CW-1:0]               y_raw;
  logic [CW-1:0]               x_ld;
  logic [CW-1:0]               y_ld;

  always_comb begin
    if ((attr_byte & ste_pkg::SIZE_MASK) == ste_pkg::SIZE_LARGE) begin
      size_ld = ste_pkg::SZ_4X4;
      low_ld  = 4'd0;
    end else if ((attr_byte & ste_pkg::SIZE_MASK) == ste_pkg::SIZE_MID) begin
      size_ld = ste_pkg::SZ_2X2;
      low_ld  = {attr_byte[5], 1'b0, attr_byte[4], 1'b0};
    end else begin
      size_ld = ste_pkg::SZ_1X1;
      low_ld  = attr_byte[7:4];
    end
    bank_add = code_byte[7] ? (tile_bank_r ? ste_pkg::BANK_WEIGHT_HI
                                           : ste_pkg::BANK_WEIGHT_LO)
                            : '0;
    base_ld  = {2'b00, code_byte[6:0], 4'b0000} + bank_add
             + {{(ste_pkg::TILE_W-4){1'b0}}, low_ld};
    // sprite side in pixels: 8 << size
    span_ld  = {{(CW-4){1'b0}}, 4'd8} << size_ld;
    x_raw    = {2'b00, sprite_x_high, attr_byte[0]};
    y_raw    = {3'b000, sprite_y};
    if (flip_screen_r) begin
      x_ld = {1'b0, screen_width_r}  - x_raw - span_ld;
      y_ld = {1'b0, screen_height_r} - y_raw - span_ld;
    end else begin
      x_ld = x_raw;
      y_ld = y_raw;
    end
  end

  // per-sprite walk registers
  logic [ste_pkg::TILE_W-1:0] tile_r, tile_nxt;
  logic [CW-1:0]              x0_r;
  logic [CW-1:0]              y0_r;
  logic                       fx_r;
  logic                       fy_r;
  logic [1:0]                 side_max_r;
  logic [1:0]                 row_r, row_nxt;
  logic [1:0]                 col_r, col_nxt;

  // walk position: flip order within the sprite
  logic [1:0]    dx;
  logic [1:0]    dy;
  logic [CW-1:0] px;
  logic [CW-1:0] py;
  logic          row_end;

  always_comb begin
    dx      = fx_r ? (side_max_r ^ col_r) : col_r;
    dy      = fy_r ? (side_max_r ^ row_r) : row_r;
    px      = x0_r + {{(CW-5){1'b0}}, dx, 3'b000};
    py      = y0_r + {{(CW-5){1'b0}}, dy, 3'b000};
    row_end = (col_r == side_max_r);
    sts.last = row_end && (row_r == side_max_r);
    // next tile: one more, plus two after each row of a 2x2 sprite
    if (row_end) begin
      col_nxt  = 2'd0;
      row_nxt  = row_r + 2'd1;
      tile_nxt = tile_r + ((side_max_r == 2'd1) ? 13'd3 : 13'd1);
    end else begin
      col_nxt  = col_r + 2'd1;
      row_nxt  = row_r;
      tile_nxt = tile_r + 13'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tile_r     <= base_ld;
      x0_r       <= x_ld;
      y0_r       <= y_ld;
      fx_r       <= attr_byte[1] ^ flip_screen_r;
      fy_r       <= attr_byte[2] ^ flip_screen_r;
      side_max_r <= (size_ld == ste_pkg::SZ_4X4) ? 2'd3 :
                    (size_ld == ste_pkg::SZ_2X2) ? 2'd1 : 2'd0;
      row_r      <= 2'd0;
      col_r      <= 2'd0;
    end else if (cmd.step) begin
      tile_r <= tile_nxt;
      row_r  <= row_nxt;
      col_r  <= col_nxt;
    end
  end

  // output word register
  logic [ste_pkg::TILE_W-1:0] o_tile_r;
  logic [CW-1:0]              o_x_r;
  logic [CW-1:0]              o_y_r;
  logic [CW-1:0]              o_wrap_r;
  logic                       o_mx_r;
  logic                       o_my_r;
  logic                       o_last_r;

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      o_tile_r <= tile_r;
      o_x_r    <= px;
      o_y_r    <= py;
      o_wrap_r <= py - ste_pkg::WRAP_OFFSET;
      o_mx_r   <= fx_r;
      o_my_r   <= fy_r;
      o_last_r <= sts.last;
    end
  end

  assign out_tdata = {2'b00, o_wrap_r, o_y_r, o_x_r, o_tile_r};
  assign out_tuser = {o_my_r, o_mx_r};
  assign out_tlast = o_last_r;

endmodule

// ----- rtl/ste_ctrl.sv -----
// controller: accepts a sprite, paces the tile walk against the output word register
`include "sprite_tile_expander_defines.svh"

module ste_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  output ste_pkg::ste_cmd_t  cmd,
  input  ste_pkg::ste_sts_t  sts
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic slot_free;

  // commands and next state
  always_comb begin
    slot_free     = !out_valid_r || out_tready;
    in_tready     = (state_r == ST_IDLE);
    cmd.load      = in_tvalid && in_tready;
    cmd.step      = 1'b0;
    state_nxt     = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.load) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        cmd.step = slot_free;
        if (slot_free && sts.last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
    out_valid_nxt = cmd.step ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  // checks
  `STE_ASSERT(a_load_starts_walk, cmd.load |=> (state_r == ST_RUN), "walk did not start after load")
  `STE_ASSERT(a_last_ends_walk, (cmd.step && sts.last) |=> (state_r == ST_IDLE), "walk did not end on last tile")
  `STE_ASSERT(a_no_overwrite, (out_valid_r && !out_tready) |-> !cmd.step, "output word overwritten while stalled")
  `STE_ASSERT_RST(a_reset_clean, !rst_n |=> (state_r == ST_IDLE && !out_valid_r), "controller not clear after reset")

endmodule

// ----- rtl/sprite_tile_expander.sv -----
// top level of the sprite tile expander
// Takes one 4-byte sprite entry per input word and emits one output word per 8x8 tile
// (1, 4 or 16 tiles for a 1x1, 2x2 or 4x4 sprite), row by row in flip order, with tlast
// on the final tile. An entry is accepted only while the tile walk is idle: it is
// loaded, then one tile per cycle moves from the walk counter into the output word
// register while that register is empty or being read. The next entry may be accepted
// while the last tile still waits in the output register. The user must write the
// configuration (bank, flip screen, screen size) only while the block is idle; unchecked.
module sprite_tile_expander (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [ste_pkg::IDX_W-1:0]           cfg_index,
  input  logic [ste_pkg::SCREEN_W-1:0]        cfg_wdata,
  // sprite entry input
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [7:0] sprite_y, [15:8] sprite_x_high, [23:16] attr_byte, [31:24] code_byte
  input  logic [ste_pkg::IN_DATA_W-1:0]       in_tdata,
  // tile output
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [12:0] tile_number, [23:13] draw_x, [34:24] draw_y, [45:35] wrap_y, [47:46] zero
  output logic [ste_pkg::OUT_DATA_W-1:0]      out_tdata,
  // [0] mirror_x, [1] mirror_y
  output logic [ste_pkg::OUT_USER_W-1:0]      out_tuser,
  output logic                                out_tlast
);

  ste_pkg::ste_cmd_t cmd;
  ste_pkg::ste_sts_t sts;

  // control
  ste_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  // datapath
  ste_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- tb/tb.sv -----
// self-checking testbench of the sprite tile expander
`timescale 1ns / 1ps

module tb;
  import ste_pkg::*;

  // one expected or observed tile, fields in output word order
  typedef struct packed {
    logic [TILE_W-1:0]  tile_number;
    logic [COORD_W-1:0] draw_x;
    logic [COORD_W-1:0] draw_y;
    logic [COORD_W-1:0] wrap_y;
    logic               mirror_x;
    logic               mirror_y;
    logic               last_tile;
  } tile_t;

  // tile predictor and queue of tiles still owed by the block
  class tile_scoreboard;
    tile_t               tiles_due[$];
    logic                bank;
    logic                flip;
    logic [SCREEN_W-1:0] width;
    logic [SCREEN_W-1:0] height;
    int                  errors;

    function new();
      bank   = 1'b0;
      flip   = 1'b0;
      width  = SCREEN_WIDTH_RST;
      height = SCREEN_HEIGHT_RST;
      errors = 0;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [SCREEN_W-1:0] value);
      case (idx)
        CFG_TILE_BANK:     bank = value[0];
        CFG_FLIP_SCREEN:   flip = value[0];
        CFG_SCREEN_WIDTH:  width = value;
        CFG_SCREEN_HEIGHT: height = value;
        default: ;
      endcase
    endfunction

    function int pending();
      return tiles_due.size();
    endfunction

    // expand one accepted sprite entry into its tiles
    function void note_sprite(logic [IN_DATA_W-1:0] entry);
      logic [BYTE_W-1:0] ypos;
      logic [BYTE_W-1:0] xhi;
      logic [BYTE_W-1:0] attr;
      logic [BYTE_W-1:0] code;
      logic [TILE_W-1:0] tile;
      logic [3:0]        low;
      logic              mx;
      logic              my;
      int                n;
      int                x0;
      int                y0;
      int                px;
      int                py;
      int                wy;
      tile_t             t;
      ypos = entry[7:0];
      xhi  = entry[15:8];
      attr = entry[23:16];
      code = entry[31:24];
      mx   = attr[1];
      my   = attr[2];
      x0   = int'({xhi, attr[0]});
      y0   = int'(ypos);
      // size decode and low code bits
      if ((attr & SIZE_MASK) == SIZE_LARGE) begin
        n   = 4;
        low = 4'd0;
      end else if ((attr & SIZE_MASK) == SIZE_MID) begin
        n   = 2;
        low = {attr[5], 1'b0, attr[4], 1'b0};
      end else begin
        n   = 1;
        low = attr[7:4];
      end
      // flip screen mirrors position and inverts both flips
      if (flip) begin
        x0 = int'(width) - x0 - n * 8;
        y0 = int'(height) - y0 - n * 8;
        mx = !mx;
        my = !my;
      end
      tile = {2'b00, code[6:0], 4'b0000} + {{(TILE_W-4){1'b0}}, low} +
             (code[7] ? (bank ? BANK_WEIGHT_HI : BANK_WEIGHT_LO) : '0);
      // walk rows then columns in flip order
      for (int r = 0; r < n; r++) begin
        py = (my ? (n - 1 - r) : r) * 8 + y0;
        wy = py - int'(WRAP_OFFSET);
        for (int c = 0; c < n; c++) begin
          px = (mx ? (n - 1 - c) : c) * 8 + x0;
          t.tile_number = tile;
          t.draw_x      = px[COORD_W-1:0];
          t.draw_y      = py[COORD_W-1:0];
          t.wrap_y      = wy[COORD_W-1:0];
          t.mirror_x    = mx;
          t.mirror_y    = my;
          t.last_tile   = (r == n - 1) && (c == n - 1);
          tiles_due.push_back(t);
          tile = tile + 13'd1;
        end
        if (n == 2) tile = tile + 13'd2;
      end
    endfunction

    // compare one accepted tile with the oldest owed one
    function void check_tile(tile_t got);
      tile_t want;
      if (tiles_due.size() == 0) begin
        if (errors < 10)
          $display("%0t: unexpected tile tile=%h x=%h y=%h wy=%h mx=%b my=%b last=%b",
                   $realtime, got.tile_number, got.draw_x, got.draw_y, got.wrap_y,
                   got.mirror_x, got.mirror_y, got.last_tile);
        errors++;
      end else begin
        want = tiles_due.pop_front();
        if (got !== want) begin
          if (errors < 10) begin
            $display("%0t: tile mismatch", $realtime);
            $display("  exp tile=%h x=%h y=%h wy=%h mx=%b my=%b last=%b",
                     want.tile_number, want.draw_x, want.draw_y, want.wrap_y,
                     want.mirror_x, want.mirror_y, want.last_tile);
            $display("  got tile=%h x=%h y=%h wy=%h mx=%b my=%b last=%b",
                     got.tile_number, got.draw_x, got.draw_y, got.wrap_y,
                     got.mirror_x, got.mirror_y, got.last_tile);
          end
          errors++;
        end
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [IDX_W-1:0]      cfg_index = '0;
  logic [SCREEN_W-1:0]   cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  out_tlast;

  logic                  calm = 1'b0;
  int                    ready_hold = 0;
  tile_t                 seen;
  tile_scoreboard        sb = new();

  // entries as {code, attr, x high, y}: sizes, flips, banks, field extremes
  logic [IN_DATA_W-1:0] directed_sprites[$] = '{
    32'h00_00_00_00, 32'hff_ff_ff_ff, 32'h80_08_00_ff, 32'h7f_88_ff_00,
    32'h00_80_12_34, 32'h00_f0_00_00, 32'h01_38_10_20, 32'h02_0a_20_30,
    32'h03_0c_40_50, 32'h04_0e_60_70, 32'h05_8a_80_90, 32'h06_8c_a0_b0,
    32'h07_8e_c0_c0, 32'h08_01_ff_ff, 32'h80_f7_ff_ff, 32'hff_8f_fe_fe,
    32'hc0_28_00_ff, 32'h40_18_ff_00, 32'h00_06_00_00, 32'h80_88_00_00,
    32'h7f_3f_7f_80, 32'haa_55_aa_55, 32'h55_aa_55_aa
  };

  sprite_tile_expander dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // output back-pressure: random stall bursts between ready runs
  always @(posedge clk) begin
    if (calm) begin
      out_tready <= 1'b1;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (out_tready && $urandom_range(0, 2) == 0) begin
      out_tready <= 1'b0;
      ready_hold <= $urandom_range(0, 16);
    end else begin
      out_tready <= 1'b1;
      ready_hold <= $urandom_range(0, 40);
    end
  end

  // tile monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen = {out_tdata[12:0], out_tdata[23:13], out_tdata[34:24], out_tdata[45:35],
              out_tuser[0], out_tuser[1], out_tlast};
      sb.check_tile(seen);
    end
  end

  // offer one sprite entry, sometimes after an idle burst
  task send_sprite(logic [IN_DATA_W-1:0] entry);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_tdata  <= entry;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_sprite(entry);
  endtask

  task write_reg(logic [IDX_W-1:0] idx, logic [SCREEN_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    sb.set_reg(idx, value);
  endtask

  // stop offering and wait for every owed tile
  task drain_tiles();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task write_regs(logic bank, logic flip, logic [SCREEN_W-1:0] w, logic [SCREEN_W-1:0] h);
    write_reg(CFG_TILE_BANK, {9'd0, bank});
    write_reg(CFG_FLIP_SCREEN, {9'd0, flip});
    write_reg(CFG_SCREEN_WIDTH, w);
    write_reg(CFG_SCREEN_HEIGHT, h);
    cfg_we <= 1'b0;
  endtask

  // main sequence
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed_sprites[i]) send_sprite(directed_sprites[i]);
    for (int p = 0; p < 9; p++) begin
      if (p > 0) begin
        drain_tiles();
        case (p)
          1: write_regs(1'b1, 1'b0, 10'd512, 10'd256);
          2: write_regs(1'b0, 1'b1, 10'd512, 10'd256);
          3: write_regs(1'b1, 1'b1, 10'd1, 10'd1);
          4: write_regs(1'b0, 1'b1, 10'd1023, 10'd1023);
          5: write_regs(1'b1, 1'b1, 10'd0, 10'd0);
          6: write_regs(1'b0, 1'b1, SCREEN_W'($urandom_range(1, 512)),
                        SCREEN_W'($urandom_range(1, 512)));
          7: write_regs(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        SCREEN_W'($urandom_range(0, 1023)),
                        SCREEN_W'($urandom_range(0, 1023)));
          default: begin
            write_regs(1'b0, 1'b0, 10'd512, 10'd256);
            calm <= 1'b1;
          end
        endcase
      end
      repeat (43) send_sprite($urandom());
    end
    drain_tiles();
    repeat (20) @(posedge clk);
    if (sb.errors == 0)
      $display("PASS sprite_tile_expander");
    else
      $display("FAIL sprite_tile_expander");
    $finish;
  end

  // run limit
  initial begin
    #8_000_000;
    $display("FAIL sprite_tile_expander");
    $finish;
  end

endmodule

// ----- sprite_tile_expander.f -----
+incdir+rtl
rtl/ste_pkg.sv
rtl/ste_datapath.sv
rtl/ste_ctrl.sv
rtl/sprite_tile_expander.sv
tb/tb.sv
